/* rtl/dnsw_pkg.sv */
// ----------------------------------------------------------------------------
// dnsw_pkg
// Types, codes and helper functions shared by the wire-name-to-text decoder.
// ----------------------------------------------------------------------------
package dnsw_pkg;

	localparam int LIMIT_WIDTH = 10;
	localparam int LEN_WIDTH   = 10;
	localparam int FIFO_DEPTH  = 4;
	localparam int FIFO_AW     = $clog2(FIFO_DEPTH);
	localparam int ESC_ROOM    = 5;

	localparam logic [LIMIT_WIDTH-1:0] LIMIT_RESET = 10'd490;

	localparam logic [1:0] KIND_CHAR  = 2'd0;
	localparam logic [1:0] KIND_DONE  = 2'd1;
	localparam logic [1:0] KIND_ERROR = 2'd2;

	localparam logic [7:0] CH_OPEN  = 8'h7b;
	localparam logic [7:0] CH_CLOSE = 8'h7d;
	localparam logic [7:0] CH_DOT   = 8'h2e;

	typedef enum logic [1:0] {
		OP_DONE,
		OP_ERROR,
		OP_SAFE,
		OP_ESC
	} op_t;

	typedef enum logic [1:0] {
		TAIL_NONE,
		TAIL_DOT,
		TAIL_ERR
	} tail_t;

	typedef struct packed {
		logic [7:0] wire_byte;
		logic       first_byte;
	} in_item_t;

	typedef struct packed {
		logic [7:0]           out_char;
		logic [1:0]           kind;
		logic [LEN_WIDTH-1:0] name_length;
		logic                 last;
	} out_item_t;

	typedef struct packed {
		op_t                  op;
		tail_t                tail;
		logic [7:0]           data;
		logic [LEN_WIDTH-1:0] name_length;
	} cmd_t;

	function automatic logic [7:0] hex_digit(input logic [3:0] v);
		logic [7:0] r;
		if (v < 4'd10) begin
			r = 8'h30 + {4'd0, v};
		end else begin
			r = 8'h61 + {4'd0, v - 4'd10};
		end
		return r;
	endfunction

	function automatic logic is_safe(input logic [7:0] b);
		return (b >= 8'h30 && b <= 8'h39) || (b >= 8'h61 && b <= 8'h7a) ||
		       (b >= 8'h41 && b <= 8'h5a) || b == 8'h2d || b == 8'h5f;
	endfunction

endpackage

/* rtl/dnsw_front.sv */
// ----------------------------------------------------------------------------
// dnsw_front
// Accepts wire bytes, tracks label and position state, and classifies each
// byte into at most one decode command for the back end.
// ----------------------------------------------------------------------------
module dnsw_front #(
	parameter int POSITION_WIDTH = 10
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [dnsw_pkg::LIMIT_WIDTH-1:0]  cfg_data,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  dnsw_pkg::in_item_t                in_item,
	input  logic                              q_full,
	output logic                              q_push,
	output dnsw_pkg::cmd_t                    q_cmd
);

	localparam int CW = ((POSITION_WIDTH > dnsw_pkg::LIMIT_WIDTH) ?
		POSITION_WIDTH : dnsw_pkg::LIMIT_WIDTH) + 1;

	logic [dnsw_pkg::LIMIT_WIDTH-1:0] output_limit_q;
	logic [6:0]                       label_remaining_q;
	logic [POSITION_WIDTH-1:0]        input_position_q;
	logic [POSITION_WIDTH-1:0]        output_position_q;
	logic                             name_active_q;

	logic [6:0]                lr, lr_n;
	logic [POSITION_WIDTH-1:0] ip, ip_n, op, op_n;
	logic                      active, active_n;
	logic [CW-1:0]             lim_w;
	logic                      accept;
	logic                      gen;
	dnsw_pkg::cmd_t            cmd;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;
	assign lim_w    = CW'(output_limit_q);

	always_comb begin
		lr       = in_item.first_byte ? 7'd0 : label_remaining_q;
		ip       = in_item.first_byte ? '0 : input_position_q;
		op       = in_item.first_byte ? '0 : output_position_q;
		active   = in_item.first_byte || name_active_q;
		lr_n     = lr;
		ip_n     = ip;
		op_n     = op;
		active_n = active;
		gen      = 1'b0;
		cmd      = '{op: dnsw_pkg::OP_ERROR, tail: dnsw_pkg::TAIL_NONE,
			data: in_item.wire_byte, name_length: '0};
		if (active) begin
			if (lr == 7'd0) begin
				if (in_item.wire_byte == 8'd0 || in_item.wire_byte[7]) begin
					gen      = 1'b1;
					active_n = 1'b0;
					if (CW'(op) >= lim_w) begin
						cmd.op = dnsw_pkg::OP_ERROR;
					end else begin
						cmd.op          = dnsw_pkg::OP_DONE;
						cmd.name_length = dnsw_pkg::LEN_WIDTH'(ip);
					end
				end else begin
					lr_n = in_item.wire_byte[6:0];
				end
			end else if (CW'(ip) >= lim_w || CW'(op) >= lim_w) begin
				gen      = 1'b1;
				active_n = 1'b0;
				cmd.op   = dnsw_pkg::OP_ERROR;
			end else begin
				gen  = 1'b1;
				ip_n = ip + 1'b1;
				if (dnsw_pkg::is_safe(in_item.wire_byte)) begin
					cmd.op = dnsw_pkg::OP_SAFE;
					op_n   = op + 1'b1;
				end else if (CW'(op) + CW'(dnsw_pkg::ESC_ROOM) >= lim_w) begin
					cmd.op   = dnsw_pkg::OP_ERROR;
					active_n = 1'b0;
				end else begin
					cmd.op = dnsw_pkg::OP_ESC;
					op_n   = op + POSITION_WIDTH'(4);
				end
				if (cmd.op != dnsw_pkg::OP_ERROR) begin
					lr_n = lr - 7'd1;
					if (lr_n == 7'd0) begin
						ip_n = ip + POSITION_WIDTH'(2);
						if (CW'(op_n) >= lim_w) begin
							cmd.tail = dnsw_pkg::TAIL_ERR;
							active_n = 1'b0;
						end else begin
							cmd.tail = dnsw_pkg::TAIL_DOT;
							op_n     = op_n + 1'b1;
						end
					end
				end
			end
		end
	end

	assign q_push = accept && gen;
	assign q_cmd  = cmd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			output_limit_q    <= dnsw_pkg::LIMIT_RESET;
			label_remaining_q <= '0;
			input_position_q  <= '0;
			output_position_q <= '0;
			name_active_q     <= 1'b0;
		end else begin
			if (cfg_we) begin
				output_limit_q <= cfg_data;
			end
			if (accept) begin
				label_remaining_q <= lr_n;
				input_position_q  <= ip_n;
				output_position_q <= op_n;
				name_active_q     <= active_n;
			end
		end
	end

endmodule

/* rtl/dnsw_fifo.sv */
// ----------------------------------------------------------------------------
// dnsw_fifo
// Short command queue between the classifier and the character sequencer.
// ----------------------------------------------------------------------------
module dnsw_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  dnsw_pkg::cmd_t push_cmd,
	input  logic           pop,
	output dnsw_pkg::cmd_t head,
	output logic           full,
	output logic           empty
);

	dnsw_pkg::cmd_t                 mem [dnsw_pkg::FIFO_DEPTH];
	logic [dnsw_pkg::FIFO_AW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [dnsw_pkg::FIFO_AW:0]     count_q;

	assign full  = count_q == (dnsw_pkg::FIFO_AW+1)'(dnsw_pkg::FIFO_DEPTH);
	assign empty = count_q == '0;
	assign head  = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push) else $error("push into full queue");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		empty |-> !pop) else $error("pop from empty queue");

endmodule

/* rtl/dnsw_back.sv */
// ----------------------------------------------------------------------------
// dnsw_back
// Expands each queued command into its text characters or end result, one
// per cycle while the output is not stalled, into a registered output stage.
// ----------------------------------------------------------------------------
module dnsw_back (
	input  logic                clk,
	input  logic                arst_n,
	input  dnsw_pkg::cmd_t      head,
	input  logic                q_empty,
	output logic                q_pop,
	output logic                out_valid,
	input  logic                out_ready,
	output dnsw_pkg::out_item_t out_item
);

	logic [2:0]          step_q;
	logic [2:0]          body_n, total_n;
	logic                advance, is_last;
	logic                out_valid_q;
	dnsw_pkg::out_item_t out_q;
	dnsw_pkg::out_item_t res;

	always_comb begin
		case (head.op)
			dnsw_pkg::OP_ESC: body_n = 3'd4;
			default:          body_n = 3'd1;
		endcase
		total_n = body_n + {2'd0, head.tail != dnsw_pkg::TAIL_NONE};
		is_last = step_q == total_n - 3'd1;
		res      = '0;
		res.last = is_last;
		case (head.op)
			dnsw_pkg::OP_DONE: begin
				res.kind        = dnsw_pkg::KIND_DONE;
				res.name_length = head.name_length;
			end
			dnsw_pkg::OP_ERROR: begin
				res.kind = dnsw_pkg::KIND_ERROR;
			end
			default: begin
				if (step_q == body_n) begin
					if (head.tail == dnsw_pkg::TAIL_ERR) begin
						res.kind = dnsw_pkg::KIND_ERROR;
					end else begin
						res.out_char = dnsw_pkg::CH_DOT;
					end
				end else if (head.op == dnsw_pkg::OP_SAFE) begin
					res.out_char = head.data;
				end else begin
					case (step_q)
						3'd0:    res.out_char = dnsw_pkg::CH_OPEN;
						3'd1:    res.out_char = dnsw_pkg::hex_digit(head.data[7:4]);
						3'd2:    res.out_char = dnsw_pkg::hex_digit(head.data[3:0]);
						default: res.out_char = dnsw_pkg::CH_CLOSE;
					endcase
				end
			end
		endcase
	end

	assign advance   = !q_empty && (!out_valid_q || out_ready);
	assign q_pop     = advance && is_last;
	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	always_ff @(posedge clk) begin
		if (advance) begin
			out_q <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				step_q      <= is_last ? 3'd0 : step_q + 3'd1;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		step_q <= 3'd4) else $error("sequencer step out of range");
	a_step_needs_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		step_q != 3'd0 |-> !q_empty) else $error("mid-command with empty queue");

endmodule

/* rtl/dns_wire_name_to_text.sv */
// ----------------------------------------------------------------------------
// dns_wire_name_to_text
// Decodes a DNS wire-format name, one byte per input transaction, into its
// text form, one character (or done / error result) per output transaction.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_ready/in_item carry wire bytes; first_byte marks the first
//   length byte of a name. out_valid/out_ready/out_item carry results; last
//   flags the final result caused by one input byte. cfg_we/cfg_data write
//   the output limit; the user must write it only while the block is idle,
//   which the block itself does not enforce. A byte's command is queued,
//   then the sequencer loads its results into the output register.
//   Throughput: one result per cycle out of the sequencer while the output
//   is not stalled; a byte yields zero to five results. A four-entry command
//   queue lets the input take one byte per cycle while it is not full.
//   When the receiver stalls, the output register holds its result and the
//   queue fills; in_ready drops once it is full.
//   Reset clears the name state and the queue and sets the limit to 490.
// ----------------------------------------------------------------------------
module dns_wire_name_to_text #(
	parameter int POSITION_WIDTH = 10
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [dnsw_pkg::LIMIT_WIDTH-1:0]  cfg_data,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  dnsw_pkg::in_item_t                in_item,
	output logic                              out_valid,
	input  logic                              out_ready,
	output dnsw_pkg::out_item_t               out_item
);

	logic           q_push, q_pop, q_full, q_empty;
	dnsw_pkg::cmd_t q_cmd, q_head;

	dnsw_front #(
		.POSITION_WIDTH(POSITION_WIDTH)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_item  (in_item),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_cmd    (q_cmd)
	);

	dnsw_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_cmd (q_cmd),
		.pop      (q_pop),
		.head     (q_head),
		.full     (q_full),
		.empty    (q_empty)
	);

	dnsw_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (q_head),
		.q_empty   (q_empty),
		.q_pop     (q_pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

endmodule
